// File: hw/rtl/ntt_pkg.sv
package ntt_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 64;

	typedef enum logic [1:0] {
		KIND_INSERT       = 2'd0,
		KIND_LOOKUP_ORIG  = 2'd1,
		KIND_LOOKUP_TRANS = 2'd2,
		KIND_DELETE       = 2'd3
	} ntt_kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} ntt_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} ntt_state_t;

	typedef struct packed {
		logic [31:0] orig_ip;
		logic [15:0] orig_port;
		logic [31:0] trans_ip;
		logic [15:0] trans_port;
	} ntt_entry_t;

	typedef struct packed {
		logic accept;
		logic scan_step;
		logic capture;
		logic shift_begin;
		logic shift_step;
		logic dec;
		logic publish;
	} ntt_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic hit;
		logic last;
		logic shift_end;
		logic req_del;
	} ntt_sts_t;

endpackage

// File: hw/rtl/nat_translation_table.sv
// One request at a time; the next request is accepted the cycle after its result is loaded.
// Insert, and lookup or delete on an empty table, skip the scan and go straight to done.
// Lookup and delete scan from index 0 to the first match, or to the last entry on a miss.
// A delete that hits then moves each later entry down one place per cycle through the
// table memory's separate read and write ports; a stalled result holds.
// Reset clears the entry count and all control state; the table memory is not cleared.
module nat_translation_table
	import ntt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] orig_ip,
	input  logic [15:0] orig_port,
	input  logic [31:0] trans_ip,
	input  logic [15:0] trans_port,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] match_orig_ip,
	output logic [15:0] match_orig_port,
	output logic [31:0] match_trans_ip,
	output logic [15:0] match_trans_port
);

	ntt_cmd_t cmd;
	ntt_sts_t sts;

	ntt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ntt_dpath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (kind),
		.orig_ip         (orig_ip),
		.orig_port       (orig_port),
		.trans_ip        (trans_ip),
		.trans_port      (trans_port),
		.status          (status),
		.match_orig_ip   (match_orig_ip),
		.match_orig_port (match_orig_port),
		.match_trans_ip  (match_trans_ip),
		.match_trans_port(match_trans_port)
	);

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after accepting a request");

	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid)
		else $error("published result not presented");

	a_shift_only_delete: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_begin |-> sts.req_del && sts.hit)
		else $error("entry shift started without a delete hit");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.scan_step, cmd.shift_step, cmd.publish}))
		else $error("conflicting datapath commands");
`endif

endmodule

// File: hw/rtl/ntt_ram.sv
module ntt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/ntt_ctrl.sv
module ntt_ctrl
	import ntt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	output logic       out_valid,
	input  logic       out_stall,
	input  ntt_sts_t   sts,
	output ntt_cmd_t   cmd
);

	ntt_state_t state_q;
	ntt_state_t state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (kind == KIND_INSERT || sts.cnt_zero) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (sts.hit) begin
					cmd.capture = 1'b1;
					if (sts.req_del) begin
						cmd.shift_begin = 1'b1;
						state_d         = ST_SHIFT;
					end else begin
						state_d = ST_DONE;
					end
				end else if (sts.last) begin
					state_d = ST_DONE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (sts.shift_end) begin
					cmd.dec = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: hw/rtl/ntt_dpath.sv
module ntt_dpath
	import ntt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ntt_cmd_t    cmd,
	output ntt_sts_t    sts,
	input  logic [1:0]  kind,
	input  logic [31:0] orig_ip,
	input  logic [15:0] orig_port,
	input  logic [31:0] trans_ip,
	input  logic [15:0] trans_port,
	output logic [1:0]  status,
	output logic [31:0] match_orig_ip,
	output logic [15:0] match_orig_port,
	output logic [31:0] match_trans_ip,
	output logic [15:0] match_trans_port
);

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rd_ptr_q;
	logic [CW-1:0] cmp_ptr_q;
	logic          pend_q;
	logic [1:0]    req_kind_q;
	ntt_entry_t    req_q;
	logic [1:0]    res_status_q;
	ntt_entry_t    res_q;
	logic [1:0]    out_status_q;
	ntt_entry_t    out_q;

	ntt_entry_t    in_entry;
	ntt_entry_t    rd_entry;
	ntt_entry_t    wr_entry;
	logic          full;
	logic          ins_we;
	logic          shift_we;
	logic          match;
	logic [CW-1:0] prev_ptr;
	logic [AW-1:0] waddr;

	assign in_entry = '{orig_ip: orig_ip, orig_port: orig_port,
		trans_ip: trans_ip, trans_port: trans_port};

	assign full     = (cnt_q == CW'(TABLE_DEPTH));
	assign ins_we   = cmd.accept && (kind == KIND_INSERT) && !full;
	assign shift_we = cmd.shift_step && pend_q;
	assign prev_ptr = cmp_ptr_q - CW'(1);
	assign waddr    = ins_we ? cnt_q[AW-1:0] : prev_ptr[AW-1:0];
	assign wr_entry = ins_we ? in_entry : rd_entry;

	ntt_ram #(
		.WIDTH($bits(ntt_entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ins_we || shift_we),
		.waddr(waddr),
		.wdata(wr_entry),
		.raddr(rd_ptr_q[AW-1:0]),
		.rdata(rd_entry)
	);

	always_comb begin
		if (req_kind_q == KIND_LOOKUP_TRANS) begin
			match = (rd_entry.trans_ip == req_q.trans_ip) &&
				(rd_entry.trans_port == req_q.trans_port);
		end else begin
			match = (rd_entry.orig_ip == req_q.orig_ip) &&
				(rd_entry.orig_port == req_q.orig_port);
		end
	end

	assign sts.cnt_zero  = (cnt_q == '0);
	assign sts.hit       = pend_q && match;
	assign sts.last      = pend_q && (cmp_ptr_q == cnt_q - CW'(1));
	assign sts.shift_end = (rd_ptr_q >= cnt_q);
	assign sts.req_del   = (req_kind_q == KIND_DELETE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_ptr_q  <= '0;
			cmp_ptr_q <= '0;
			pend_q    <= 1'b0;
		end else begin
			if (cmd.accept) begin
				rd_ptr_q <= '0;
				pend_q   <= 1'b0;
				if (ins_we) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end else if (cmd.scan_step || cmd.shift_step) begin
				pend_q    <= (rd_ptr_q < cnt_q);
				cmp_ptr_q <= rd_ptr_q;
				rd_ptr_q  <= rd_ptr_q + CW'(1);
			end else if (cmd.shift_begin) begin
				rd_ptr_q <= cmp_ptr_q + CW'(1);
				pend_q   <= 1'b0;
			end
			if (cmd.dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_kind_q <= kind;
			req_q      <= in_entry;
			res_q      <= '0;
			if (kind != KIND_INSERT) begin
				res_status_q <= STAT_NOT_FOUND;
			end else if (full) begin
				res_status_q <= STAT_FULL;
			end else begin
				res_status_q <= STAT_OK;
			end
		end else if (cmd.capture) begin
			res_q        <= rd_entry;
			res_status_q <= STAT_OK;
		end
		if (cmd.publish) begin
			out_status_q <= res_status_q;
			out_q        <= res_q;
		end
	end

	assign status           = out_status_q;
	assign match_orig_ip    = out_q.orig_ip;
	assign match_orig_port  = out_q.orig_port;
	assign match_trans_ip   = out_q.trans_ip;
	assign match_trans_port = out_q.trans_port;

endmodule

// File: bench/tb_nat_translation_table.sv
import ntt_pkg::*;

typedef struct packed {
	ntt_status_t status;
	ntt_entry_t  pair;
} table_answer_t;

class nat_table_scoreboard;
	int depth;
	int errors;
	ntt_entry_t pairs[$];
	table_answer_t answers_due[$];

	function new(int table_depth);
		depth = table_depth;
		errors = 0;
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function void note_request(ntt_kind_t op, ntt_entry_t req);
		table_answer_t ans;
		int hit;
		bit same;
		ans.status = STAT_OK;
		ans.pair = '0;
		hit = -1;
		if (op == KIND_INSERT) begin
			if (pairs.size() >= depth)
				ans.status = STAT_FULL;
			else
				pairs.push_back(req);
		end else begin
			foreach (pairs[i]) begin
				if (op == KIND_LOOKUP_TRANS)
					same = pairs[i].trans_ip == req.trans_ip
						&& pairs[i].trans_port == req.trans_port;
				else
					same = pairs[i].orig_ip == req.orig_ip
						&& pairs[i].orig_port == req.orig_port;
				if (hit < 0 && same)
					hit = i;
			end
			if (hit < 0) begin
				ans.status = STAT_NOT_FOUND;
			end else begin
				ans.pair = pairs[hit];
				if (op == KIND_DELETE)
					pairs.delete(hit);
			end
		end
		answers_due.push_back(ans);
	endfunction

	task check_answer(logic [1:0] st, logic [31:0] oip, logic [15:0] oport,
			logic [31:0] tip, logic [15:0] tport);
		table_answer_t ans;
		if (answers_due.size() == 0) begin
			report($sformatf("result status %0d arrived with no request outstanding", st));
		end else begin
			ans = answers_due.pop_front();
			if (st !== ans.status)
				report($sformatf("status %0d, expected %s", st, ans.status.name()));
			if (oip !== ans.pair.orig_ip)
				report($sformatf("match_orig_ip %h, expected %h", oip, ans.pair.orig_ip));
			if (oport !== ans.pair.orig_port)
				report($sformatf("match_orig_port %h, expected %h", oport,
					ans.pair.orig_port));
			if (tip !== ans.pair.trans_ip)
				report($sformatf("match_trans_ip %h, expected %h", tip, ans.pair.trans_ip));
			if (tport !== ans.pair.trans_port)
				report($sformatf("match_trans_port %h, expected %h", tport,
					ans.pair.trans_port));
		end
	endtask
endclass

module tb_nat_translation_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = DEFAULT_TABLE_DEPTH;
	localparam int KEY_POOL = 12;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [31:0] orig_ip;
	logic [15:0] orig_port;
	logic [31:0] trans_ip;
	logic [15:0] trans_port;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [31:0] match_orig_ip;
	logic [15:0] match_orig_port;
	logic [31:0] match_trans_ip;
	logic [15:0] match_trans_port;

	nat_table_scoreboard sb;
	logic [47:0] orig_keys[KEY_POOL];
	logic [47:0] trans_keys[KEY_POOL];
	bit idling_on;
	int hold_len;

	nat_translation_table #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.orig_ip(orig_ip),
		.orig_port(orig_port),
		.trans_ip(trans_ip),
		.trans_port(trans_port),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.match_orig_ip(match_orig_ip),
		.match_orig_port(match_orig_port),
		.match_trans_ip(match_trans_ip),
		.match_trans_port(match_trans_port)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// The receiver stalls in short random bursts, or for one long stretch on demand.
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len != 0) begin
				n = hold_len;
				hold_len = 0;
				out_stall = 1'b1;
				repeat (n - 1) @(negedge clk);
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(0, 10)) @(negedge clk);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_answer(status, match_orig_ip, match_orig_port, match_trans_ip,
				match_trans_port);
	end

	task automatic send_request(ntt_kind_t op, ntt_entry_t req);
		@(negedge clk);
		kind = op;
		orig_ip = req.orig_ip;
		orig_port = req.orig_port;
		trans_ip = req.trans_ip;
		trans_port = req.trans_port;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_request(op, req);
	endtask

	task automatic pause_sender(int n);
		@(negedge clk);
		in_valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.answers_due.size() != 0) @(posedge clk);
	endtask

	function automatic logic [47:0] pick_key(bit trans_side);
		int r;
		int idx;
		r = $urandom_range(0, 99);
		idx = $urandom_range(0, KEY_POOL - 1);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		if (r < 22)
			return {$urandom(), 16'($urandom())};
		return trans_side ? trans_keys[idx] : orig_keys[idx];
	endfunction

	task automatic run_mix(int count, int ins_pct, int lo_pct, int lt_pct, int hold_at);
		ntt_kind_t op;
		ntt_entry_t req;
		int r;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_len = 300;
			r = $urandom_range(0, 99);
			if (r < ins_pct)
				op = KIND_INSERT;
			else if (r < ins_pct + lo_pct)
				op = KIND_LOOKUP_ORIG;
			else if (r < ins_pct + lo_pct + lt_pct)
				op = KIND_LOOKUP_TRANS;
			else
				op = KIND_DELETE;
			{req.orig_ip, req.orig_port} = pick_key(1'b0);
			{req.trans_ip, req.trans_port} = pick_key(1'b1);
			send_request(op, req);
			if (idling_on && $urandom_range(0, 3) == 0)
				pause_sender($urandom_range(1, 11));
		end
	endtask

	initial begin
		ntt_entry_t zeros;
		ntt_entry_t ones;
		ntt_entry_t first_pair;
		ntt_entry_t dup_pair;
		ntt_entry_t stray;
		sb = new(DEPTH);
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_INSERT;
		orig_ip = '0;
		orig_port = '0;
		trans_ip = '0;
		trans_port = '0;
		idling_on = 1'b1;
		hold_len = 0;
		foreach (orig_keys[i]) begin
			orig_keys[i] = {$urandom(), 16'($urandom())};
			trans_keys[i] = {$urandom(), 16'($urandom())};
		end
		zeros = '0;
		ones = '1;
		first_pair = {orig_keys[0], trans_keys[0]};
		dup_pair = {orig_keys[0], trans_keys[1]};
		stray = {$urandom(), 16'($urandom()), $urandom(), 16'($urandom())};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(KIND_LOOKUP_ORIG, zeros);
		send_request(KIND_LOOKUP_TRANS, ones);
		send_request(KIND_DELETE, zeros);
		send_request(KIND_INSERT, zeros);
		send_request(KIND_INSERT, ones);
		send_request(KIND_INSERT, first_pair);
		send_request(KIND_INSERT, dup_pair);
		send_request(KIND_LOOKUP_ORIG, zeros);
		send_request(KIND_LOOKUP_ORIG, ones);
		send_request(KIND_LOOKUP_ORIG, first_pair);
		send_request(KIND_LOOKUP_TRANS, dup_pair);
		send_request(KIND_LOOKUP_TRANS, ones);
		send_request(KIND_LOOKUP_ORIG, stray);
		send_request(KIND_LOOKUP_TRANS, stray);
		send_request(KIND_DELETE, first_pair);
		send_request(KIND_LOOKUP_ORIG, first_pair);
		send_request(KIND_DELETE, stray);
		send_request(KIND_DELETE, zeros);
		send_request(KIND_DELETE, dup_pair);
		send_request(KIND_DELETE, ones);
		send_request(KIND_LOOKUP_ORIG, ones);
		wait_drained();

		// Fill the table past full, with one long receiver hold while requests keep coming.
		run_mix(100, 85, 5, 5, 40);
		run_mix(250, 30, 25, 20, -1);
		run_mix(100, 15, 20, 15, -1);
		wait_drained();
		run_mix(70, 90, 5, 5, -1);
		idling_on = 1'b0;
		run_mix(120, 35, 20, 15, -1);
		wait_drained();
		repeat (150) @(posedge clk);

		if (sb.errors == 0 && sb.answers_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
